// ===== rtl/imufp_pkg.sv =====
// Shared types and constants for the IMU frame parser.
`default_nettype none

package imufp_pkg;

    localparam int FRAME_LEN = 11;
    localparam int WIN_LEN   = FRAME_LEN - 1;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int RAW_W     = 16;
    localparam int AXIS_W    = 31;

    localparam logic [7:0] HDR_SYNC   = 8'h55;
    localparam logic [7:0] HDR_MASK   = 8'h50;
    localparam logic [7:0] CODE_ACCEL = 8'h51;
    localparam logic [7:0] CODE_RATE  = 8'h52;
    localparam logic [7:0] CODE_ANGLE = 8'h53;
    localparam logic [7:0] CODE_MAG   = 8'h54;

    localparam logic [CFG_W-1:0] FS_MAX = 16'd32768;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_FS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_FS = 2'd2;

    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_RATE  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;
    localparam logic [1:0] KIND_MAG   = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_z;
        logic [CFG_W-1:0]        scale;
    } imufp_item_t;

endpackage

`default_nettype wire

// ===== rtl/imufp_front.sv =====
// Byte window, header check, frame classification and full-scale registers.
`default_nettype none

module imufp_front
    import imufp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_fire,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output logic                      push,
    output imufp_item_t               push_item
);

    // Last ten bytes received; the incoming byte completes an 11-byte frame.
    logic [7:0]       win_reg [WIN_LEN];
    logic [7:0]       win_next [WIN_LEN];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CFG_W-1:0] accel_fs_reg;
    logic [CFG_W-1:0] rate_fs_reg;
    logic [CFG_W-1:0] angle_fs_reg;
    logic [CFG_W-1:0] cfg_clamped;
    logic             frame_full;
    logic             header_ok;
    logic             kind_known;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_clamped = CFG_W'(1);
        end
        else if (cfg_data > FS_MAX)
        begin
            cfg_clamped = FS_MAX;
        end
        else
        begin
            cfg_clamped = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_fs_reg <= 16'd16;
            rate_fs_reg  <= 16'd2000;
            angle_fs_reg <= 16'd180;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ACCEL_FS: accel_fs_reg <= cfg_clamped;
                REG_RATE_FS:  rate_fs_reg  <= cfg_clamped;
                REG_ANGLE_FS: angle_fs_reg <= cfg_clamped;
                default:      ;
            endcase
        end
    end

    assign frame_full = (count_reg == CNT_W'(WIN_LEN));
    assign header_ok  = (win_reg[0] == HDR_SYNC) && ((win_reg[1] & HDR_MASK) == HDR_MASK);

    always_comb
    begin
        push_item.raw_x = {win_reg[3], win_reg[2]};
        push_item.raw_y = {win_reg[5], win_reg[4]};
        push_item.raw_z = {win_reg[7], win_reg[6]};
        kind_known      = 1'b1;
        case (win_reg[1])
            CODE_ACCEL:
            begin
                push_item.kind  = KIND_ACCEL;
                push_item.scale = accel_fs_reg;
            end
            CODE_RATE:
            begin
                push_item.kind  = KIND_RATE;
                push_item.scale = rate_fs_reg;
            end
            CODE_ANGLE:
            begin
                push_item.kind  = KIND_ANGLE;
                push_item.scale = angle_fs_reg;
            end
            CODE_MAG:
            begin
                push_item.kind  = KIND_MAG;
                push_item.scale = CFG_W'(1);
            end
            default:
            begin
                push_item.kind  = KIND_MAG;
                push_item.scale = CFG_W'(1);
                kind_known      = 1'b0;
            end
        endcase
    end

    assign push = in_fire && frame_full && header_ok && kind_known;

    always_comb
    begin
        for (int i = 0; i < WIN_LEN - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[WIN_LEN - 1] = rx_byte;

        // A bad header keeps ten bytes, which slides the frame by one.
        if (!frame_full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (header_ok)
        begin
            count_next = '0;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (in_fire)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            win_reg <= win_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/imufp_queue.sv =====
// Short queue of classified frames between the front and back ends.
`default_nettype none

module imufp_queue
    import imufp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire imufp_item_t  push_item,
    input  wire logic         pop,
    output imufp_item_t       head_item,
    output logic              full,
    output logic              empty
);

    localparam int QCNT_W = $clog2(DEPTH + 1);

    imufp_item_t       entry_reg [DEPTH];
    imufp_item_t       entry_next [DEPTH];
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic [QCNT_W-1:0] wr_slot;

    assign full      = (count_reg == QCNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[0];

    // Head stays at slot zero; a pop shifts every entry down by one.
    assign wr_slot = count_reg - QCNT_W'(pop);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entry_next[i] = entry_reg[i];
            if (pop && (i < DEPTH - 1))
            begin
                entry_next[i] = entry_reg[i + 1];
            end
            if (push && (wr_slot == QCNT_W'(i)))
            begin
                entry_next[i] = push_item;
            end
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("push did not grow the queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/imufp_back.sv =====
// Full-scale multiply of the three axes into the output register.
`default_nettype none

module imufp_back
    import imufp_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_empty,
    input  wire imufp_item_t              head_item,
    output logic                          pop,
    input  wire logic                     out_stall,
    output logic                          out_valid,
    output logic [1:0]                    frame_kind,
    output logic signed [AXIS_W-1:0]      axis_x,
    output logic signed [AXIS_W-1:0]      axis_y,
    output logic signed [AXIS_W-1:0]      axis_z
);

    logic                             valid_reg;
    logic [1:0]                       kind_reg;
    logic signed [AXIS_W-1:0]         x_reg;
    logic signed [AXIS_W-1:0]         y_reg;
    logic signed [AXIS_W-1:0]         z_reg;
    logic signed [RAW_W+CFG_W:0]      prod_x;
    logic signed [RAW_W+CFG_W:0]      prod_y;
    logic signed [RAW_W+CFG_W:0]      prod_z;
    logic signed [CFG_W:0]            scale_s;

    // Load a new result when the output register is empty or being taken.
    assign pop     = !q_empty && (!valid_reg || !out_stall);
    assign scale_s = $signed({1'b0, head_item.scale});
    assign prod_x  = head_item.raw_x * scale_s;
    assign prod_y  = head_item.raw_y * scale_s;
    assign prod_z  = head_item.raw_z * scale_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= head_item.kind;
            x_reg    <= prod_x[AXIS_W-1:0];
            y_reg    <= prod_y[AXIS_W-1:0];
            z_reg    <= prod_z[AXIS_W-1:0];
        end
    end

    assign out_valid  = valid_reg;
    assign frame_kind = kind_reg;
    assign axis_x     = x_reg;
    assign axis_y     = y_reg;
    assign axis_z     = z_reg;

endmodule

`default_nettype wire

// ===== rtl/imu_frame_parser.sv =====
// IMU frame parser: top level joining front end, queue and back end.
//
// Input channel: one serial byte per transfer on rx_byte (in_valid/in_stall).
// Output channel: one result per good frame with a known kind: frame_kind and
// the three axes, each raw * full scale in Q.15 (raw for magnetic field).
// Config port: cfg_wr_en writes cfg_data to register cfg_index
// (0 accel, 1 rate, 2 angle full scale; 0 clamps to 1, above 32768 to 32768).
// Throughput: one byte per cycle while in_stall is low. The last byte of a
// frame classifies it into the queue on its transfer; the frame is then
// multiplied into the output register once that register is empty or taken.
// The queue holds QUEUE_DEPTH frames; in_stall rises only when it is full,
// which takes QUEUE_DEPTH frames piling up behind a stalled output result.
// Reset empties the byte window, queue and output register and restores the
// full-scale registers to 16, 2000 and 180. While out_stall is high the
// output holds its result; bytes keep flowing until the queue fills.
`default_nettype none

module imu_frame_parser
    import imufp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [7:0]               rx_byte,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [1:0]                    frame_kind,
    output logic signed [AXIS_W-1:0]      axis_x,
    output logic signed [AXIS_W-1:0]      axis_y,
    output logic signed [AXIS_W-1:0]      axis_z,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data
);

    logic        in_fire;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    imufp_item_t push_item;
    imufp_item_t head_item;

    assign in_stall = q_full;
    assign in_fire  = in_valid && !in_stall;

    imufp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .rx_byte   (rx_byte),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_item (push_item)
    );

    imufp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    imufp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head_item  (head_item),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .frame_kind (frame_kind),
        .axis_x     (axis_x),
        .axis_y     (axis_y),
        .axis_z     (axis_z)
    );

endmodule

`default_nettype wire

// ===== dv/imu_frame_parser_tb.sv =====
// Self-checking testbench for imu_frame_parser with a frame predictor.
module imu_frame_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import imufp_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_BYTES   = 140;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    // header second byte with the mask bits missing, and one with them set but no known kind
    localparam logic [7:0] CODE_NO_MASK = 8'h41;
    localparam logic [7:0] CODE_UNKNOWN = 8'h5F;

    typedef struct {
        logic [1:0]               kind;
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } reading_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [7:0]               rx_byte = 8'h00;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               frame_kind;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_ACCEL_FS;
    logic [CFG_W-1:0]         cfg_data = '0;

    logic [7:0]       tx_bytes [$];
    reading_t         readings_due [$];
    logic [7:0]       win [FRAME_LEN];
    int               win_fill = 0;
    logic [CFG_W-1:0] full_scale [3] = '{16'd16, 16'd2000, 16'd180};
    logic [7:0]       known_codes [4] = '{CODE_ACCEL, CODE_RATE, CODE_ANGLE, CODE_MAG};

    bit idle_on = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int mismatches = 0;
    int bytes_taken = 0;
    int cycle_count = 0;
    int in_stall_cycles = 0;
    int settings_used = 1;
    int kind_seen [4] = '{0, 0, 0, 0};

    imu_frame_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_kind (frame_kind),
        .axis_x     (axis_x),
        .axis_y     (axis_y),
        .axis_z     (axis_z),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int run_length();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_W-1:0] limit_scale(logic [CFG_W-1:0] v);
        if (v == '0)
            return CFG_W'(1);
        if (v > FS_MAX)
            return FS_MAX;
        return v;
    endfunction

    function automatic logic signed [AXIS_W-1:0] scale_axis(logic [7:0] lo, logic [7:0] hi,
                                                            logic [CFG_W-1:0] s);
        logic signed [47:0] prod;
        prod = $signed({hi, lo}) * $signed({1'b0, s});
        return prod[AXIS_W-1:0];
    endfunction

    function automatic logic [15:0] pick_raw();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 16'h8000;
        if (r < 8)
            return 16'h7FFF;
        if (r < 10)
            return 16'h0000;
        if (r < 12)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Advance the frame window by one byte and queue the reading it completes, if any.
    task automatic take_byte(logic [7:0] b);
        reading_t         due;
        logic [CFG_W-1:0] s;
        bit               known;
        win[win_fill] = b;
        win_fill++;
        if (win_fill < FRAME_LEN)
            return;
        if (win[0] != HDR_SYNC || (win[1] & HDR_MASK) != HDR_MASK)
        begin
            for (int i = 0; i < FRAME_LEN - 1; i++)
                win[i] = win[i + 1];
            win_fill = FRAME_LEN - 1;
            return;
        end
        win_fill = 0;
        known = 1'b1;
        s = CFG_W'(1);
        due.kind = KIND_MAG;
        case (win[1])
            CODE_ACCEL:
            begin
                due.kind = KIND_ACCEL;
                s = full_scale[REG_ACCEL_FS];
            end
            CODE_RATE:
            begin
                due.kind = KIND_RATE;
                s = full_scale[REG_RATE_FS];
            end
            CODE_ANGLE:
            begin
                due.kind = KIND_ANGLE;
                s = full_scale[REG_ANGLE_FS];
            end
            CODE_MAG:
                due.kind = KIND_MAG;
            default:
                known = 1'b0;
        endcase
        if (!known)
            return;
        due.x = scale_axis(win[2], win[3], s);
        due.y = scale_axis(win[4], win[5], s);
        due.z = scale_axis(win[6], win[7], s);
        readings_due.insert(readings_due.size(), due);
    endtask

    task automatic flag_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Sender: hold the byte while stalled, then advance to the next one after an optional gap.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                take_byte(rx_byte);
                bytes_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (tx_bytes.size() > 0)
                begin
                    in_valid <= 1'b1;
                    rx_byte <= tx_bytes.pop_front();
                    gap_left <= (idle_on && $urandom_range(0, 99) < 30) ? run_length() : 0;
                end
                else
                    in_valid <= 1'b0;
            end
            if (in_stall)
                in_stall_cycles++;
        end
    end

    // Receiver: one long hold-off on request, otherwise random stall runs.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 99) < 20)
        begin
            stall_left <= run_length() - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        reading_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (readings_due.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d x %0d y %0d z %0d",
                         $time, frame_kind, axis_x, axis_y, axis_z);
                mismatches++;
            end
            else
            begin
                due = readings_due.pop_front();
                flag_field("frame_kind", due.kind, frame_kind);
                flag_field("axis_x", due.x, axis_x);
                flag_field("axis_y", due.y, axis_y);
                flag_field("axis_z", due.z, axis_z);
                kind_seen[frame_kind]++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d bytes queued, %0d readings outstanding",
                     $time, tx_bytes.size(), readings_due.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic append_byte(logic [7:0] b);
        tx_bytes.insert(tx_bytes.size(), b);
    endtask

    task automatic add_frame(logic [7:0] code, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        append_byte(HDR_SYNC);
        append_byte(code);
        append_byte(x[7:0]);
        append_byte(x[15:8]);
        append_byte(y[7:0]);
        append_byte(y[15:8]);
        append_byte(z[7:0]);
        append_byte(z[15:8]);
        // fourth value and checksum carry no result
        repeat (3) append_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic add_noise(int n);
        repeat (n) append_byte(8'($urandom_range(0, 255)));
    endtask

    // Mostly well-formed frames; the rest is noise, cut frames and odd headers.
    task automatic add_random_chunk();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            add_frame(known_codes[$urandom_range(0, 3)], pick_raw(), pick_raw(), pick_raw());
        else if (r < 78)
            add_frame(8'($urandom_range(0, 255)) | HDR_MASK, pick_raw(), pick_raw(), pick_raw());
        else if (r < 86)
            add_noise($urandom_range(1, 6));
        else if (r < 93)
        begin
            add_frame(known_codes[$urandom_range(0, 3)], pick_raw(), pick_raw(), pick_raw());
            repeat ($urandom_range(1, 10)) void'(tx_bytes.pop_back());
        end
        else
            add_frame(8'($urandom_range(0, 255)), pick_raw(), pick_raw(), pick_raw());
    endtask

    task automatic write_scales(logic [CFG_W-1:0] acc, logic [CFG_W-1:0] rate,
                                logic [CFG_W-1:0] ang);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ACCEL_FS;
        cfg_data <= acc;
        full_scale[REG_ACCEL_FS] = limit_scale(acc);
        @(posedge clk);
        cfg_index <= REG_RATE_FS;
        cfg_data <= rate;
        full_scale[REG_RATE_FS] = limit_scale(rate);
        @(posedge clk);
        cfg_index <= REG_ANGLE_FS;
        cfg_data <= ang;
        full_scale[REG_ANGLE_FS] = limit_scale(ang);
        // the spare index must be ignored
        @(posedge clk);
        cfg_index <= REG_SPARE;
        cfg_data <= CFG_W'($urandom_range(0, 65535));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (tx_bytes.size() != 0 || in_valid || readings_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int start_len;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset scales, every kind, raw extremes, then broken headers and a last accel frame
        add_frame(CODE_ACCEL, 16'h7FFF, 16'h8000, 16'h0000);
        add_frame(CODE_RATE, 16'hFFFF, 16'h0001, 16'h8000);
        add_frame(CODE_ANGLE, 16'h1234, 16'hEDCC, 16'h7FFF);
        add_frame(CODE_MAG, 16'h8000, 16'h7FFF, 16'hFFFF);
        append_byte(8'hFF);
        append_byte(8'h00);
        add_frame(CODE_NO_MASK, 16'h0102, 16'h0304, 16'h0506);
        add_frame(CODE_UNKNOWN, 16'h8000, 16'h8000, 16'h8000);
        add_frame(CODE_ACCEL, 16'h0001, 16'hFFFF, 16'h4000);
        drain();

        // zero clamps up to one, above full range clamps down
        write_scales(16'd0, 16'hFFFF, FS_MAX + 16'd1);
        @(negedge clk);
        add_frame(CODE_ACCEL, 16'h8000, 16'h7FFF, 16'hFFFF);
        add_frame(CODE_RATE, 16'h8000, 16'h7FFF, 16'hFFFF);
        add_frame(CODE_ANGLE, 16'h8000, 16'h7FFF, 16'h0000);
        drain();

        // fill the block while the output is held off
        write_scales(FS_MAX, FS_MAX, FS_MAX);
        @(negedge clk);
        idle_on = 1'b0;
        hold_req = 1'b1;
        repeat (40)
            add_frame(known_codes[$urandom_range(0, 3)], pick_raw(), pick_raw(), pick_raw());
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                write_scales(16'd1, 16'd1, 16'd1);
            else
                write_scales(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 40000)),
                             CFG_W'($urandom_range(0, 4000)));
            @(negedge clk);
            idle_on = (p != 3);
            start_len = tx_bytes.size();
            while (tx_bytes.size() - start_len < PHASE_BYTES)
                add_random_chunk();
            drain();
        end

        $display("Ran %0d bytes under %0d scale settings: %0d accel, %0d rate, %0d angle, %0d mag",
                 bytes_taken, settings_used, kind_seen[KIND_ACCEL], kind_seen[KIND_RATE],
                 kind_seen[KIND_ANGLE], kind_seen[KIND_MAG]);
        $display("Input held off by the block for %0d cycles; %0d mismatches",
                 in_stall_cycles, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
